FILE: src/sopa_pkg.sv
// ============================================================================
// sopa_pkg
// shared types, widths and saturating arithmetic for the segmented
// outer-product accumulator
// ============================================================================
package sopa_pkg;

    localparam int ELEM_W = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 48;
    localparam int SEG_W  = 10;
    localparam int POS_W  = 2;
    localparam int VEC_N  = 4;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic mac;    // add this row's product
        logic clr;    // start from zero instead of the held sum
        logic load;   // copy held sum into the drain slot
        logic shift;  // drain slot takes the neighbor's value
    } t_cell_ctrl;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [ACC_W:0] s;
        s = {acc[ACC_W-1], acc} + {{(ACC_W+1-PROD_W){prod[PROD_W-1]}}, prod};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

FILE: src/sopa_if.sv
// ============================================================================
// sopa_if
// valid/ready channels for input rows and emitted block values
// ============================================================================
interface sopa_in_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic [sopa_pkg::SEG_W-1:0]          segment_index;
    logic signed [sopa_pkg::ELEM_W-1:0]  a_elem_0;
    logic signed [sopa_pkg::ELEM_W-1:0]  a_elem_1;
    logic signed [sopa_pkg::ELEM_W-1:0]  a_elem_2;
    logic signed [sopa_pkg::ELEM_W-1:0]  a_elem_3;
    logic signed [sopa_pkg::ELEM_W-1:0]  b_elem_0;
    logic signed [sopa_pkg::ELEM_W-1:0]  b_elem_1;
    logic signed [sopa_pkg::ELEM_W-1:0]  b_elem_2;
    logic signed [sopa_pkg::ELEM_W-1:0]  b_elem_3;

    modport source (
        output valid, operation, segment_index,
               a_elem_0, a_elem_1, a_elem_2, a_elem_3,
               b_elem_0, b_elem_1, b_elem_2, b_elem_3,
        input  ready
    );
    modport sink (
        input  valid, operation, segment_index,
               a_elem_0, a_elem_1, a_elem_2, a_elem_3,
               b_elem_0, b_elem_1, b_elem_2, b_elem_3,
        output ready
    );
endinterface

interface sopa_out_if;
    logic                               valid;
    logic                               ready;
    logic [sopa_pkg::SEG_W-1:0]         out_segment;
    logic [sopa_pkg::POS_W-1:0]         row_pos;
    logic [sopa_pkg::POS_W-1:0]         col_pos;
    logic signed [sopa_pkg::ACC_W-1:0]  sum_value;
    logic                               last;

    modport source (
        output valid, out_segment, row_pos, col_pos, sum_value, last,
        input  ready
    );
    modport sink (
        input  valid, out_segment, row_pos, col_pos, sum_value, last,
        output ready
    );
endinterface

FILE: src/segmented_outer_product_accumulate.sv
// ============================================================================
// segmented_outer_product_accumulate
// accumulates outer products of A and B rows per segment into a chain of
// saturating accumulator cells and emits each finished block value by value
// ============================================================================
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------
//  i_row    | in  | valid / ready | operation, segment_index, a_elem_*, b_elem_*
//  o_sum    | out | valid / ready | out_segment, row_pos, col_pos, sum_value, last
//
//  one row request per cycle while ready is high; each cell does its
//  multiply-accumulate in the cycle the row is taken
//  a request that closes a segment copies all sums into the drain chain at
//  once; the chain then shifts one value per cycle toward o_sum while
//  o_sum.ready is high, so a block leaves while new rows keep accumulating
//  a second closing request waits only while the previous block is still in
//  the chain (ready drops for that request alone)
//  synchronous active-low reset clears the control state; no clearing pass,
//  the sums restart from zero whenever a segment opens
//
module segmented_outer_product_accumulate #(
    parameter int SEGMENTS = 1024,
    parameter int A_LEN    = 4,
    parameter int B_LEN    = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sopa_in_if.sink     i_row,
    sopa_out_if.source  o_sum
);

    // number of cells in the chain and width of the drain counter
    localparam int N_CELLS = A_LEN * B_LEN;
    localparam int CNT_W   = $clog2(N_CELLS + 1);
    localparam int LIM_W   = 17;

    localparam logic [LIM_W-1:0]                SEG_LIMIT = LIM_W'(SEGMENTS);
    localparam logic [CNT_W-1:0]                CNT_FULL  = CNT_W'(N_CELLS);
    localparam logic [CNT_W-1:0]                CNT_ONE   = CNT_W'(1);
    localparam logic [sopa_pkg::POS_W-1:0]      COL_LAST  = sopa_pkg::POS_W'(B_LEN - 1);

    // open segment bookkeeping
    logic                           r_open;
    logic [sopa_pkg::SEG_W-1:0]     r_open_seg;

    // drain side: values left in the chain and position of the head value
    logic [CNT_W-1:0]               r_cnt;
    logic [sopa_pkg::SEG_W-1:0]     r_drain_seg;
    logic [sopa_pkg::POS_W-1:0]     r_row;
    logic [sopa_pkg::POS_W-1:0]     r_col;

    logic                           w_in_range;
    logic                           w_is_flush;
    logic                           w_closes;
    logic                           w_drain_free;
    logic                           w_accept;
    logic                           w_shift;
    sopa_pkg::t_cell_ctrl           w_ctrl;

    logic signed [sopa_pkg::ELEM_W-1:0] w_a [sopa_pkg::VEC_N];
    logic signed [sopa_pkg::ELEM_W-1:0] w_b [sopa_pkg::VEC_N];
    logic signed [sopa_pkg::ACC_W-1:0]  w_drain [N_CELLS+1];

    assign w_a[0] = i_row.a_elem_0;
    assign w_a[1] = i_row.a_elem_1;
    assign w_a[2] = i_row.a_elem_2;
    assign w_a[3] = i_row.a_elem_3;
    assign w_b[0] = i_row.b_elem_0;
    assign w_b[1] = i_row.b_elem_1;
    assign w_b[2] = i_row.b_elem_2;
    assign w_b[3] = i_row.b_elem_3;

    // request decode
    always_comb begin
        w_is_flush = (i_row.operation == sopa_pkg::OP_FLUSH);
        w_in_range = (LIM_W'(i_row.segment_index) < SEG_LIMIT);
        if (w_is_flush) begin
            w_closes = r_open;
        end else begin
            w_closes = w_in_range && r_open && (i_row.segment_index != r_open_seg);
        end
        // chain can take a new block if empty or its final value leaves now
        w_drain_free = (r_cnt == '0) || ((r_cnt == CNT_ONE) && o_sum.ready);
        i_row.ready  = !w_closes || w_drain_free;
        w_accept     = i_row.valid && i_row.ready;
        w_shift      = o_sum.valid && o_sum.ready;

        w_ctrl.load  = w_accept && w_closes;
        w_ctrl.mac   = w_accept && !w_is_flush && w_in_range;
        w_ctrl.clr   = !r_open || w_closes;
        w_ctrl.shift = w_shift;
    end

    // chain of cells, head at index zero in row-major order
    assign w_drain[N_CELLS] = '0;

    for (genvar gi = 0; gi < A_LEN; gi++) begin : g_row
        for (genvar gj = 0; gj < B_LEN; gj++) begin : g_col
            sopa_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_ctrl),
                .i_a        (w_a[gi]),
                .i_b        (w_b[gj]),
                .i_shift_in (w_drain[gi*B_LEN + gj + 1]),
                .o_drain    (w_drain[gi*B_LEN + gj])
            );
        end
    end

    // open segment tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open     <= 1'b0;
            r_open_seg <= '0;
        end else if (w_accept) begin
            if (w_is_flush) begin
                r_open <= 1'b0;
            end else if (w_in_range) begin
                r_open     <= 1'b1;
                r_open_seg <= i_row.segment_index;
            end
        end
    end

    // drain position and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_row <= '0;
            r_col <= '0;
        end else if (w_ctrl.load) begin
            r_cnt <= CNT_FULL;
            r_row <= '0;
            r_col <= '0;
        end else if (w_shift) begin
            r_cnt <= r_cnt - CNT_ONE;
            if (r_col == COL_LAST) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load) begin
            r_drain_seg <= r_open_seg;
        end
    end

    // result channel straight from the chain head and drain counters
    assign o_sum.valid       = (r_cnt != '0);
    assign o_sum.out_segment = r_drain_seg;
    assign o_sum.row_pos     = r_row;
    assign o_sum.col_pos     = r_col;
    assign o_sum.sum_value   = w_drain[0];
    assign o_sum.last        = (r_cnt == CNT_ONE);

    // a closing request always starts a block at its first position
    a_close_starts_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_closes) |=>
            (o_sum.valid && o_sum.row_pos == '0 && o_sum.col_pos == '0))
        else $error("closed segment did not start emitting");

    // after a final value leaves, either nothing shows or a fresh block starts
    a_last_ends_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_sum.valid && o_sum.ready && o_sum.last) |=>
            (!o_sum.valid || (o_sum.row_pos == '0 && o_sum.col_pos == '0)))
        else $error("block continued past its last value");

    // a taken flush leaves no segment open
    a_flush_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_flush) |=> !r_open)
        else $error("segment still open after flush");

    // a row in range always leaves its segment open
    a_row_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_is_flush && w_in_range) |=>
            (r_open && r_open_seg == $past(i_row.segment_index)))
        else $error("accumulated row did not open its segment");

endmodule

FILE: src/sopa_cell.sv
// ============================================================================
// sopa_cell
// one accumulator of the block: multiply-accumulate with saturation, plus a
// drain slot that hands its value to the neighbor toward the output
// ============================================================================
module sopa_cell (
    input  logic                                i_clk,
    input  sopa_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [sopa_pkg::ELEM_W-1:0]  i_a,
    input  logic signed [sopa_pkg::ELEM_W-1:0]  i_b,
    input  logic signed [sopa_pkg::ACC_W-1:0]   i_shift_in,
    output logic signed [sopa_pkg::ACC_W-1:0]   o_drain
);

    logic signed [sopa_pkg::ACC_W-1:0]  r_acc;
    logic signed [sopa_pkg::ACC_W-1:0]  n_acc;
    logic signed [sopa_pkg::ACC_W-1:0]  r_drain;
    logic signed [sopa_pkg::ACC_W-1:0]  w_base;
    logic signed [sopa_pkg::PROD_W-1:0] w_prod;

    always_comb begin
        w_prod = i_a * i_b;
        w_base = i_ctrl.clr ? '0 : r_acc;
        n_acc  = sopa_pkg::sat_add(w_base, w_prod);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mac) begin
            r_acc <= n_acc;
        end
        // load wins: a finished sum replaces whatever was draining
        if (i_ctrl.load) begin
            r_drain <= r_acc;
        end else if (i_ctrl.shift) begin
            r_drain <= i_shift_in;
        end
    end

    assign o_drain = r_drain;

endmodule
